>>> rtl/acjq_pkg.sv
// Package for the ADC conversion job queue: command codes, item layouts
// and the job entry format kept in the queue memory.
// No dependencies.
package acjq_pkg;

  // Command carried in s_tuser
  typedef enum logic [0:0] {
    CMD_SUBMIT = 1'b0,
    CMD_FINISH = 1'b1
  } cmd_t;

  localparam int CHAN_W   = 5;
  localparam int TAG_W    = 8;
  localparam int SAMPLE_W = 16;
  localparam int PEND_W   = 5;

  // One queued job, as stored in the ring memory
  typedef struct packed {
    logic              want;
    logic [TAG_W-1:0]  tag;
    logic [CHAN_W-1:0] neg;
    logic [CHAN_W-1:0] pos;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Input item payload, last field in the lowest bits
  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                wants_result;
    logic [TAG_W-1:0]    job_tag;
    logic [CHAN_W-1:0]   neg_channel;
    logic [CHAN_W-1:0]   pos_channel;
  } in_item_t;

  localparam int IN_W     = $bits(in_item_t);
  localparam int IN_BYTES = (IN_W + 7) / 8;

  // Result item payload, last field in the lowest bits
  typedef struct packed {
    logic [PEND_W-1:0]   pending;
    logic [SAMPLE_W-1:0] done_value;
    logic [TAG_W-1:0]    done_tag;
    logic                done_valid;
    logic [CHAN_W-1:0]   start_neg;
    logic [CHAN_W-1:0]   start_pos;
    logic                start_conv;
    logic                accepted;
  } res_item_t;

  localparam int RES_W     = $bits(res_item_t);
  localparam int RES_BYTES = (RES_W + 7) / 8;

endpackage

>>> rtl/acjq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module acjq_ram #(
  parameter int WIDTH = 19,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/adc_conversion_job_queue.sv
// ADC conversion job queue: ring FIFO of jobs in one RAM plus a sequencer.
// Depends on acjq_pkg and acjq_ram.
//
//  channel | dir | payload                                  | handshake
//  --------+-----+------------------------------------------+-----------------
//  s_      | in  | tuser: cmd; tdata: job fields and sample | tvalid / tready
//  m_      | out | tdata: result fields                     | tvalid / tready
//
// A submit item is accepted, then loaded into the output register.
// A finish item on a non-empty queue reads the head entry and then, if jobs
// remain, the new head entry through the single RAM read port.
// One item is in flight at a time; s_tready is high only in the idle state.
// A stalled output holds the sequencer in its emit state.
// Synchronous reset clears the indices, count and handshakes; the RAM is
// never cleared, only entries holding queued jobs are used.
module adc_conversion_job_queue #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // tdata: pos_channel[4:0], neg_channel[9:5], job_tag[17:10],
  //        wants_result[18], sample[34:19], zero fill
  input  logic [acjq_pkg::IN_BYTES*8-1:0]      s_tdata,
  // tuser: cmd[0]
  input  logic                                 s_tuser,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // tdata: accepted[0], start_conv[1], start_pos[6:2], start_neg[11:7],
  //        done_valid[12], done_tag[20:13], done_value[36:21],
  //        pending[41:37], zero fill
  output logic [acjq_pkg::RES_BYTES*8-1:0]     m_tdata
);

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RD_HEAD,
    ST_RD_NEXT,
    ST_EMIT
  } state_t;

  state_t               state;
  logic [IDX_W-1:0]     head;
  logic [IDX_W-1:0]     tail;
  logic [CNT_W-1:0]     count;
  acjq_pkg::res_item_t  res;
  acjq_pkg::res_item_t  res_next;
  acjq_pkg::res_item_t  out_res;
  logic [acjq_pkg::SAMPLE_W-1:0] sample_hold;

  acjq_pkg::in_item_t   in_item;
  acjq_pkg::entry_t     wr_entry;
  acjq_pkg::entry_t     rd_entry;
  logic [acjq_pkg::ENTRY_W-1:0] rd_raw;
  logic                 in_fire;
  logic                 is_submit;
  logic                 full;
  logic                 push;
  logic                 out_free;
  logic [IDX_W-1:0]     head_next;
  logic [IDX_W-1:0]     tail_next;

  // Input decode
  assign in_item   = acjq_pkg::in_item_t'(s_tdata[acjq_pkg::IN_W-1:0]);
  assign s_tready  = (state == ST_IDLE);
  assign in_fire   = s_tvalid && s_tready;
  assign is_submit = (acjq_pkg::cmd_t'(s_tuser) == acjq_pkg::CMD_SUBMIT);
  assign full      = (count == CNT_W'(QUEUE_DEPTH));
  assign push      = in_fire && is_submit && !full;
  assign out_free  = !m_tvalid || m_tready;

  // Ring index wrap
  assign head_next = (head == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head + 1'b1;
  assign tail_next = (tail == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : tail + 1'b1;

  // Job entry written on a push
  always_comb begin
    wr_entry.want = in_item.wants_result;
    wr_entry.tag  = in_item.job_tag;
    wr_entry.neg  = in_item.neg_channel;
    wr_entry.pos  = in_item.pos_channel;
  end

  assign rd_entry = acjq_pkg::entry_t'(rd_raw);

  // Job memory; the read port always addresses the head, and an entry is
  // only used after a later finish accept, never in the cycle it is written
  acjq_ram #(
    .WIDTH(acjq_pkg::ENTRY_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (push),
    .waddr(tail),
    .wdata(wr_entry),
    .raddr(head),
    .rdata(rd_raw)
  );

  // Result assembly per sequencer state
  always_comb begin
    res_next = res;
    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          res_next         = '0;
          res_next.pending = acjq_pkg::PEND_W'(count);
          if (is_submit) begin
            if (!full) begin
              res_next.accepted = 1'b1;
              res_next.pending  = acjq_pkg::PEND_W'(count + 1'b1);
              if (count == '0) begin
                res_next.start_conv = 1'b1;
                res_next.start_pos  = in_item.pos_channel;
                res_next.start_neg  = in_item.neg_channel;
              end
            end
          end else if (count != '0) begin
            res_next.pending = acjq_pkg::PEND_W'(count - 1'b1);
          end
        end
      end
      ST_RD_HEAD: begin
        // popped entry is in rd_raw
        if (rd_entry.want) begin
          res_next.done_valid = 1'b1;
          res_next.done_tag   = rd_entry.tag;
          res_next.done_value = sample_hold;
        end
      end
      ST_RD_NEXT: begin
        res_next.start_conv = 1'b1;
        res_next.start_pos  = rd_entry.pos;
        res_next.start_neg  = rd_entry.neg;
      end
      default: ;
    endcase
  end

  // Sequencer: queue pointers, result register and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      head     <= '0;
      tail     <= '0;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      res <= res_next;
      if (state == ST_EMIT && out_free) begin
        out_res  <= res;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            sample_hold <= in_item.sample;
            state       <= ST_EMIT;
            if (is_submit) begin
              if (!full) begin
                tail  <= tail_next;
                count <= count + 1'b1;
              end
            end else if (count != '0) begin
              // pop: the old head is being read this cycle
              head  <= head_next;
              count <= count - 1'b1;
              state <= ST_RD_HEAD;
            end
          end
        end
        ST_RD_HEAD: begin
          // next head read is under way
          state <= (count != '0) ? ST_RD_NEXT : ST_EMIT;
        end
        ST_RD_NEXT: begin
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_tdata = {{(acjq_pkg::RES_BYTES*8 - acjq_pkg::RES_W){1'b0}}, out_res};

  // Occupancy never exceeds the ring size
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("job count above queue depth");

  // An empty ring has head and tail together
  a_empty_ptrs: assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> (head == tail))
    else $error("empty queue with head and tail apart");

  // Next-head read only happens when jobs remain after the pop
  a_next_read: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RD_NEXT) |-> (count != '0))
    else $error("next head read on empty queue");

  // A submit to a full queue leaves the occupancy alone
  a_full_drop: assert property (@(posedge clk) disable iff (rst)
    (in_fire && is_submit && full) |=> $stable(count))
    else $error("submit to full queue changed count");

endmodule
